/* sv/sci_pkg.sv */
// Shared constants and register codes for the segment and capsule intersection block.
package sci_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int RADIUS_BITS    = 23;
  localparam int DEGEN_BITS     = 20;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 23;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = '0;
  localparam logic [DEGEN_BITS-1:0]  DEGEN_RESET  = DEGEN_BITS'(17);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_RADIUS = 1'b0,
    REG_DEGEN  = 1'b1
  } cfg_reg_t;

endpackage

/* sv/segment_capsule_intersection.sv */
// Closest points between a query segment and a capsule axis, with a capsule hit test.
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | query segment and capsule axis endpoints
//  m_*     | out       | m_tvalid/m_tready  | squared distance, closest points, hit
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
// One request enters per cycle unless the output stalls; the two restoring dividers
// produce one quotient bit per stage.
// Reset is synchronous; it clears the valid bits and loads the configuration registers with their reset values.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall at the output holds every stage in place and nothing is lost or repeated.
module segment_capsule_intersection
  import sci_pkg::*;
#(
  parameter int COORD_BITS      = COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
  // cap_bottom_x, cap_bottom_y, cap_bottom_z, cap_top_x, cap_top_y, cap_top_z
  input  logic [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // distance_sq, near_query_x, near_query_y, near_query_z,
  // near_axis_x, near_axis_y, near_axis_z
  output logic [((2*COORD_BITS+2+6*COORD_BITS+7)/8)*8-1:0] m_tdata,
  // hit
  output logic [0:0] m_tuser,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam int C    = COORD_BITS;
  localparam int F    = PARAM_FRAC_BITS;
  localparam int D    = C + 1;
  localparam int P    = 2 * D;
  localparam int DW   = P + 2;
  localparam int HL   = (DW + 1) / 2;
  localparam int WP   = 2 * DW;
  localparam int NW1  = WP + 1;
  localparam int BSW  = DW + F + 2;
  localparam int TW   = DW + F + 3;
  localparam int QW   = F + 1;
  localparam int MW   = D + F + 2;
  localparam int SQW  = 2 * C + 2;
  localparam int DIST = 2 * C + 2;
  localparam int RSQ  = 2 * RADIUS_BITS;
  localparam int CMPW = (DIST > RSQ) ? DIST : RSQ;

  localparam int ST_IN  = 0;
  localparam int ST_PRD = 1;
  localparam int ST_DOT = 2;
  localparam int ST_PP  = 3;
  localparam int ST_WP  = 4;
  localparam int ST_D1  = 5;
  localparam int ST_BS  = 6 + F;
  localparam int ST_D2  = 7 + F;
  localparam int ST_MS  = 8 + 2 * F;
  localparam int ST_PT  = 9 + 2 * F;
  localparam int ST_SQ  = 10 + 2 * F;
  localparam int ST_OUT = 11 + 2 * F;
  localparam int NST    = 12 + 2 * F;

  localparam logic [QW-1:0] ONE = {1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [2:0][C-1:0] p1;
    logic [2:0][C-1:0] p2;
    logic [2:0][D-1:0] d1;
    logic [2:0][D-1:0] d2;
    logic [2:0][D-1:0] r;
    logic [DW-1:0]     a;
    logic [DW-1:0]     b;
    logic [DW-1:0]     c;
    logic [DW-1:0]     e;
    logic [DW-1:0]     f;
    logic              qa;
    logic              qe;
    logic [QW-1:0]     s1;
    logic [QW-1:0]     sf;
    logic [QW-1:0]     tf;
    logic              qs;
    logic              qt;
  } geo_t;

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + DW'(1)) : x;
  endfunction

  logic adv;
  logic [NST-1:0] v;
  geo_t g [NST];
  geo_t gnx [NST];

  logic [RADIUS_BITS-1:0] radius;
  logic [DEGEN_BITS-1:0] degen;
  logic [RSQ-1:0] rad_sq;

  logic signed [P-1:0] prd [5][3];
  logic [2*HL-1:0] pp [4][4];
  logic ppn [4];
  logic signed [WP-1:0] wp [4];

  logic [NW1-1:0] r1 [F+1];
  logic [NW1-1:0] dv1 [F+1];
  logic [QW-1:0] q1 [F+1];
  logic k1 [F+1];

  logic signed [BSW-1:0] bs;

  logic [TW-1:0] r2 [F+1];
  logic [TW-1:0] dv2 [F+1];
  logic [QW-1:0] q2 [F+1];
  logic k2 [F+1];

  logic signed [MW-1:0] ms [3];
  logic signed [MW-1:0] mt [3];
  logic [C-1:0] c1 [3];
  logic [C-1:0] c2 [3];
  logic [C-1:0] c1q [3];
  logic [C-1:0] c2q [3];
  logic signed [SQW-1:0] sq [3];

  logic [DIST-1:0] out_dist;
  logic [C-1:0] out_q [3];
  logic [C-1:0] out_a [3];
  logic out_hit;

  assign adv       = !v[ST_OUT] || m_tready;
  assign s_tready  = adv && !rst;
  assign cfg_ready = !rst;
  assign m_tvalid  = v[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
      degen  <= DEGEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_RADIUS: radius <= cfg_data[RADIUS_BITS-1:0];
        REG_DEGEN:  degen  <= cfg_data[DEGEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rad_sq <= RSQ'(radius) * RSQ'(radius);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[NST-2:0], s_tvalid};
    end
  end

  always_comb begin
    logic signed [DW-1:0] sa, sb, sc, se, sf;
    logic signed [C-1:0] pa, pb, pc, pt;
    logic signed [TW-1:0] tn, eone, cf, ce;
    geo_t h;
    gnx[0] = '0;
    for (int k = 0; k < 3; k++) begin
      pa = $signed(s_tdata[k*C +: C]);
      pb = $signed(s_tdata[(3+k)*C +: C]);
      pc = $signed(s_tdata[(6+k)*C +: C]);
      pt = $signed(s_tdata[(9+k)*C +: C]);
      gnx[0].p1[k] = pa;
      gnx[0].p2[k] = pc;
      gnx[0].d1[k] = D'(pb) - D'(pa);
      gnx[0].d2[k] = D'(pt) - D'(pc);
      gnx[0].r[k]  = D'(pa) - D'(pc);
    end
    for (int k = 1; k < NST; k++) begin
      gnx[k] = g[k-1];
    end
    sa = '0; se = '0; sb = '0; sc = '0; sf = '0;
    for (int k = 0; k < 3; k++) begin
      sa = sa + DW'(prd[0][k]);
      se = se + DW'(prd[1][k]);
      sb = sb + DW'(prd[2][k]);
      sc = sc + DW'(prd[3][k]);
      sf = sf + DW'(prd[4][k]);
    end
    gnx[ST_DOT].a = sa;
    gnx[ST_DOT].e = se;
    gnx[ST_DOT].b = sb;
    gnx[ST_DOT].c = sc;
    gnx[ST_DOT].f = sf;
    gnx[ST_PP].qa = g[ST_PP-1].a <= DW'(degen);
    gnx[ST_PP].qe = g[ST_PP-1].e <= DW'(degen);
    gnx[ST_BS].s1 = q1[F];

    h    = g[ST_D2-1];
    cf   = TW'($signed(h.f));
    ce   = TW'($signed(h.e));
    tn   = TW'(bs) + (cf <<< F);
    eone = ce <<< F;
    gnx[ST_D2].qs = 1'b0;
    gnx[ST_D2].qt = 1'b0;
    gnx[ST_D2].sf = '0;
    gnx[ST_D2].tf = '0;
    if (h.qa && h.qe) begin
      gnx[ST_D2].qs = 1'b0;
    end else if (h.qa) begin
      gnx[ST_D2].qt = 1'b1;
    end else if (h.qe) begin
      gnx[ST_D2].qs = 1'b1;
    end else if (tn < 0) begin
      gnx[ST_D2].qs = 1'b1;
    end else if (tn > eone) begin
      gnx[ST_D2].qs = 1'b1;
      gnx[ST_D2].tf = ONE;
    end else begin
      gnx[ST_D2].qt = 1'b1;
      gnx[ST_D2].sf = h.s1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) begin
        g[k] <= gnx[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        prd[0][k] <= $signed(g[ST_IN].d1[k]) * $signed(g[ST_IN].d1[k]);
        prd[1][k] <= $signed(g[ST_IN].d2[k]) * $signed(g[ST_IN].d2[k]);
        prd[2][k] <= $signed(g[ST_IN].d1[k]) * $signed(g[ST_IN].d2[k]);
        prd[3][k] <= $signed(g[ST_IN].d1[k]) * $signed(g[ST_IN].r[k]);
        prd[4][k] <= $signed(g[ST_IN].d2[k]) * $signed(g[ST_IN].r[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] ox [4];
    logic [DW-1:0] oy [4];
    logic [DW-1:0] mx, my;
    logic [2*HL-1:0] xl, xh, yl, yh;
    logic [WP-1:0] sum;
    if (adv) begin
      ox[0] = g[ST_DOT].a; oy[0] = g[ST_DOT].e;
      ox[1] = g[ST_DOT].b; oy[1] = g[ST_DOT].b;
      ox[2] = g[ST_DOT].b; oy[2] = g[ST_DOT].f;
      ox[3] = g[ST_DOT].c; oy[3] = g[ST_DOT].e;
      for (int j = 0; j < 4; j++) begin
        mx = mag(ox[j]);
        my = mag(oy[j]);
        xl = (2*HL)'(mx[HL-1:0]);
        xh = (2*HL)'(mx[DW-1:HL]);
        yl = (2*HL)'(my[HL-1:0]);
        yh = (2*HL)'(my[DW-1:HL]);
        pp[j][0] <= xl * yl;
        pp[j][1] <= xl * yh;
        pp[j][2] <= xh * yl;
        pp[j][3] <= xh * yh;
        ppn[j]   <= ox[j][DW-1] ^ oy[j][DW-1];
      end
      for (int j = 0; j < 4; j++) begin
        sum = WP'(pp[j][0]) + ((WP'(pp[j][1]) + WP'(pp[j][2])) << HL)
            + (WP'(pp[j][3]) << (2 * HL));
        wp[j] <= ppn[j] ? -$signed(sum) : $signed(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [NW1-1:0] den, sn;
    logic z, ge;
    if (adv) begin
      den = NW1'(wp[0]) - NW1'(wp[1]);
      sn  = NW1'(wp[2]) - NW1'(wp[3]);
      if (den == '0) begin
        den = NW1'(1);
        sn  = '0;
      end
      z  = sn <= 0;
      ge = sn >= den;
      r1[0]  <= sn;
      dv1[0] <= den;
      q1[0]  <= z ? '0 : (ge ? ONE : '0);
      k1[0]  <= z || ge;
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_div1
    always_ff @(posedge clk) begin
      logic [NW1:0] t;
      logic ge;
      if (adv) begin
        t  = {r1[i-1], 1'b0};
        ge = t >= {1'b0, dv1[i-1]};
        r1[i]  <= ge ? NW1'(t - {1'b0, dv1[i-1]}) : NW1'(t);
        dv1[i] <= dv1[i-1];
        q1[i]  <= k1[i-1] ? q1[i-1] : {q1[i-1][QW-2:0], ge};
        k1[i]  <= k1[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bs <= $signed(g[ST_BS-1].b) * $signed({1'b0, q1[F]});
    end
  end

  always_ff @(posedge clk) begin
    logic signed [TW-1:0] tn, eone, n, d, cb, cc, cf, ca, ce;
    logic z, ge;
    geo_t h;
    if (adv) begin
      h    = g[ST_D2-1];
      cb   = TW'($signed(h.b));
      cc   = TW'($signed(h.c));
      cf   = TW'($signed(h.f));
      ca   = TW'($signed(h.a));
      ce   = TW'($signed(h.e));
      tn   = TW'(bs) + (cf <<< F);
      eone = ce <<< F;
      if (h.qa && h.qe) begin
        n = '0;
        d = TW'(1);
      end else if (h.qa) begin
        n = cf;
        d = ce;
      end else if (h.qe) begin
        n = -cc;
        d = ca;
      end else if (tn < 0) begin
        n = -cc;
        d = ca;
      end else if (tn > eone) begin
        n = cb - cc;
        d = ca;
      end else begin
        n = tn;
        d = eone;
      end
      z  = n <= 0;
      ge = n >= d;
      r2[0]  <= n;
      dv2[0] <= d;
      q2[0]  <= z ? '0 : (ge ? ONE : '0);
      k2[0]  <= z || ge;
    end
  end

  for (genvar i = 1; i <= F; i++) begin : g_div2
    always_ff @(posedge clk) begin
      logic [TW:0] t;
      logic ge;
      if (adv) begin
        t  = {r2[i-1], 1'b0};
        ge = t >= {1'b0, dv2[i-1]};
        r2[i]  <= ge ? TW'(t - {1'b0, dv2[i-1]}) : TW'(t);
        dv2[i] <= dv2[i-1];
        q2[i]  <= k2[i-1] ? q2[i-1] : {q2[i-1][QW-2:0], ge};
        k2[i]  <= k2[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] s, t;
    logic signed [MW-1:0] tmp;
    logic signed [C:0] dd;
    logic [DIST-1:0] dsum;
    if (adv) begin
      s = g[ST_MS-1].qs ? q2[F] : g[ST_MS-1].sf;
      t = g[ST_MS-1].qt ? q2[F] : g[ST_MS-1].tf;
      for (int k = 0; k < 3; k++) begin
        ms[k] <= $signed(g[ST_MS-1].d1[k]) * $signed({1'b0, s});
        mt[k] <= $signed(g[ST_MS-1].d2[k]) * $signed({1'b0, t});
      end
      for (int k = 0; k < 3; k++) begin
        tmp   = MW'($signed(g[ST_PT-1].p1[k])) + (ms[k] >>> F);
        c1[k] <= tmp[C-1:0];
        tmp   = MW'($signed(g[ST_PT-1].p2[k])) + (mt[k] >>> F);
        c2[k] <= tmp[C-1:0];
      end
      for (int k = 0; k < 3; k++) begin
        dd     = (C+1)'($signed(c1[k])) - (C+1)'($signed(c2[k]));
        sq[k]  <= dd * dd;
        c1q[k] <= c1[k];
        c2q[k] <= c2[k];
      end
      dsum = DIST'(sq[0]) + DIST'(sq[1]) + DIST'(sq[2]);
      out_dist <= dsum;
      out_hit  <= CMPW'(dsum) <= CMPW'(rad_sq);
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= c1q[k];
        out_a[k] <= c2q[k];
      end
    end
  end

  always_comb begin
    m_tdata = '0;
    m_tdata[DIST-1:0] = out_dist;
    for (int k = 0; k < 3; k++) begin
      m_tdata[DIST + k*C +: C]     = out_q[k];
      m_tdata[DIST + (3+k)*C +: C] = out_a[k];
    end
    m_tuser = out_hit;
  end

  a_div1_rem : assert property (@(posedge clk) disable iff (rst)
    v[ST_D1] && !k1[0] |-> r1[0] < dv1[0])
    else $error("first divider remainder not below divisor");

  a_div2_q : assert property (@(posedge clk) disable iff (rst)
    v[ST_MS-1] |-> q2[F] <= ONE)
    else $error("second parameter above one");

  a_flow : assert property (@(posedge clk) disable iff (rst)
    adv && v[ST_OUT-1] |=> m_tvalid)
    else $error("result lost between last stages");

endmodule
